// File: src/hex_dump_line_formatter_assert.svh
// ----------------------------------------------------------------------------
// Hex dump line formatter assertion macros
// Concurrent check wrappers on clk_i / rst_ni, removable with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef HEX_DUMP_LINE_FORMATTER_ASSERT_SVH
`define HEX_DUMP_LINE_FORMATTER_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define HDLF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define HDLF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define HDLF_ASSERT(lbl, prop, msg)
`define HDLF_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// File: src/hdlf_pkg.sv
// ----------------------------------------------------------------------------
// Hex dump line formatter package
// Layout constants, character codes, sequencer states and token type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hdlf_pkg;

  localparam int BytesPerLine  = 32;
  localparam int BytesPerGroup = 4;

  localparam int FillW   = $clog2(BytesPerLine);
  localparam int ColCntW = $clog2(BytesPerLine + 1);
  localparam int SpcW    = $clog2(3 * BytesPerLine + 4);

  localparam logic [7:0] ChNewline  = 8'h0A;
  localparam logic [7:0] ChSpace    = 8'h20;
  localparam logic [7:0] ChDot      = 8'h2E;
  localparam logic [7:0] ChAmp      = 8'h26;
  localparam logic [7:0] ChLt       = 8'h3C;
  localparam logic [7:0] ChGt       = 8'h3E;
  localparam logic [7:0] ChTilde    = 8'h7E;
  localparam logic [7:0] ChZero     = 8'h30;
  localparam logic [7:0] ChAlphaOff = 8'h37;

  localparam logic [1:0] CntOne = 2'd1;
  localparam logic [1:0] CntTwo = 2'd2;

  typedef enum logic {
    FuncData = 1'b0,
    FuncEnd  = 1'b1
  } func_e;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_NL,
    SEQ_HEXH,
    SEQ_HEXL,
    SEQ_SPC,
    SEQ_COL,
    SEQ_EOL
  } seq_state_e;

  // one character request from the sequencer
  typedef struct packed {
    logic       is_mem;
    logic [7:0] lit;
    logic       last;
  } tok_t;

  typedef logic [SpcW-1:0] spc_tbl_t [BytesPerLine];

  // spaces emitted by an end marker: padding plus the three column spaces
  function automatic spc_tbl_t build_pad_tbl();
    spc_tbl_t t;
    int       n;
    for (int f = 0; f < BytesPerLine; f++) begin
      n = 3;
      for (int k = f; k < BytesPerLine; k++) begin
        n = n + 2;
        if ((k % BytesPerGroup) == 0 && k > f) n = n + 1;
      end
      t[f] = SpcW'(n);
    end
    return t;
  endfunction

  function automatic logic [BytesPerLine-1:0] build_grp_tbl();
    logic [BytesPerLine-1:0] g;
    for (int f = 0; f < BytesPerLine; f++) begin
      g[f] = (((f + 1) % BytesPerGroup) == 0);
    end
    return g;
  endfunction

  localparam spc_tbl_t                PadTbl = build_pad_tbl();
  localparam logic [BytesPerLine-1:0] GrpTbl = build_grp_tbl();

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    return (n < 4'd10) ? (ChZero + {4'h0, n}) : (ChAlphaOff + {4'h0, n});
  endfunction

  function automatic logic [7:0] shown_char(input logic [7:0] b);
    if (b >= ChSpace && b <= ChTilde && b != ChAmp && b != ChLt && b != ChGt) begin
      return b;
    end
    return ChDot;
  endfunction

endpackage

`default_nettype wire

// File: src/hdlf_pack.sv
// ----------------------------------------------------------------------------
// Hex dump line formatter character packer
// Resolves character requests, pairs them and holds the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hdlf_pack
  import hdlf_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       tok_valid_i,
  output logic            tok_ready_o,
  input  wire tok_t       tok_i,
  input  wire logic [7:0] mem_data_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      char_first_o,
  output logic [7:0]      char_second_o,
  output logic [1:0]      char_count_o,
  output logic            last_of_run_o
);

  logic       tok_v_q, tok_v_d;
  tok_t       tok_q;
  logic       half_v_q, half_v_d;
  logic [7:0] half_q;
  logic       out_v_q, out_v_d;
  logic [7:0] first_q, first_d;
  logic [7:0] second_q, second_d;
  logic [1:0] cnt_q, cnt_d;
  logic       last_q, last_d;
  logic [7:0] ch;
  logic       out_free, push, consume;

  assign ch       = tok_q.is_mem ? mem_data_i : tok_q.lit;
  assign out_free = !out_v_q || out_ready_i;
  assign push     = tok_v_q && (half_v_q || tok_q.last);
  assign consume  = tok_v_q && (!push || out_free);

  assign tok_ready_o = !tok_v_q || consume;

  always_comb begin
    tok_v_d  = tok_ready_o ? tok_valid_i : tok_v_q;
    half_v_d = half_v_q;
    out_v_d  = out_v_q && !out_ready_i;
    first_d  = first_q;
    second_d = second_q;
    cnt_d    = cnt_q;
    last_d   = last_q;
    if (consume) begin
      if (push) begin
        out_v_d  = 1'b1;
        half_v_d = 1'b0;
        last_d   = tok_q.last;
        if (half_v_q) begin
          first_d  = half_q;
          second_d = ch;
          cnt_d    = CntTwo;
        end else begin
          first_d  = ch;
          second_d = 8'h00;
          cnt_d    = CntOne;
        end
      end else begin
        half_v_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_v_q  <= 1'b0;
      half_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      tok_v_q  <= tok_v_d;
      half_v_q <= half_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok_ready_o) tok_q <= tok_i;
    if (consume && !push) half_q <= ch;
    first_q  <= first_d;
    second_q <= second_d;
    cnt_q    <= cnt_d;
    last_q   <= last_d;
  end

  assign out_valid_o   = out_v_q;
  assign char_first_o  = first_q;
  assign char_second_o = second_q;
  assign char_count_o  = cnt_q;
  assign last_of_run_o = last_q;

endmodule

`default_nettype wire

// File: src/hex_dump_line_formatter.sv
// ----------------------------------------------------------------------------
// Hex dump line formatter
// Turns a byte stream into hex dump text with an ASCII column, one or two
// chars per result.
// ----------------------------------------------------------------------------
//  channel  signals                                        direction
//  in       in_valid_i/in_ready_o, func_i, data_byte_i     request in
//  out      out_valid_o/out_ready_i, char_first_o,         request out
//           char_second_o, char_count_o, last_of_run_o
//
//  One character per cycle while out is not stalled; a new item is taken
//  only once the last one has been sequenced, and an end marker that yields
//  nothing leaves in ready again in the next cycle.
//  Reset is immediate; the column memory needs no clearing.
//  A stall on out holds the sequencer; in stays ready until the next item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "hex_dump_line_formatter_assert.svh"

module hex_dump_line_formatter
  import hdlf_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic       func_i,
  input  wire logic [7:0] data_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      char_first_o,
  output logic [7:0]      char_second_o,
  output logic [1:0]      char_count_o,
  output logic            last_of_run_o
);

  seq_state_e state_q, state_d, seq_after;
  logic       block_start_q, block_start_d;
  logic [FillW-1:0]   line_fill_q, line_fill_d;
  logic [7:0]         byte_q, byte_d;
  logic               func_q, func_d;
  logic [SpcW-1:0]    spc_q, spc_d;
  logic [ColCntW-1:0] col_cnt_q, col_cnt_d;
  logic [FillW-1:0]   col_idx_q, col_idx_d;
  logic [7:0]         ascii_mem [BytesPerLine];
  logic [7:0]         rd_q;

  logic               accept, emit, tok_ready;
  logic               tok_valid;
  tok_t               tok;
  logic [ColCntW-1:0] fill_inc;
  logic               full;
  logic [ColCntW-1:0] col_last;

  assign in_ready_o = (state_q == SEQ_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign tok_valid  = (state_q != SEQ_IDLE);
  assign emit       = tok_valid && tok_ready;
  assign fill_inc   = {1'b0, line_fill_q} + ColCntW'(1);
  assign full       = (fill_inc == ColCntW'(BytesPerLine));
  assign col_last   = col_cnt_q - ColCntW'(1);

  // item setup
  always_comb begin
    block_start_d = block_start_q;
    line_fill_d   = line_fill_q;
    byte_d        = byte_q;
    func_d        = func_q;
    spc_d         = spc_q;
    col_cnt_d     = col_cnt_q;
    col_idx_d     = col_idx_q;
    if (accept) begin
      byte_d        = data_byte_i;
      func_d        = func_i;
      block_start_d = (func_i == FuncEnd);
      col_idx_d     = '0;
      if (func_i == FuncData) begin
        line_fill_d = full ? '0 : fill_inc[FillW-1:0];
        col_cnt_d   = full ? ColCntW'(BytesPerLine) : '0;
        if (full) begin
          spc_d = SpcW'(3);
        end else if (GrpTbl[line_fill_q]) begin
          spc_d = SpcW'(1);
        end else begin
          spc_d = '0;
        end
      end else begin
        line_fill_d = '0;
        col_cnt_d   = {1'b0, line_fill_q};
        spc_d       = (line_fill_q != '0) ? PadTbl[line_fill_q] : '0;
      end
    end else if (emit) begin
      if (state_q == SEQ_SPC) spc_d = spc_q - SpcW'(1);
      if (state_q == SEQ_COL) col_idx_d = col_idx_q + FillW'(1);
    end
  end

  // next state
  always_comb begin
    seq_after = SEQ_IDLE;
    unique case (state_q)
      SEQ_IDLE: seq_after = SEQ_IDLE;
      SEQ_NL: begin
        if (func_q == FuncData) seq_after = SEQ_HEXH;
        else if (spc_q != '0)   seq_after = SEQ_SPC;
        else                    seq_after = SEQ_IDLE;
      end
      SEQ_HEXH: seq_after = SEQ_HEXL;
      SEQ_HEXL: seq_after = (spc_q != '0) ? SEQ_SPC : SEQ_IDLE;
      SEQ_SPC: begin
        if (spc_q != SpcW'(1))    seq_after = SEQ_SPC;
        else if (col_cnt_q != '0) seq_after = SEQ_COL;
        else                      seq_after = SEQ_IDLE;
      end
      SEQ_COL:  seq_after = ({1'b0, col_idx_q} == col_last) ? SEQ_EOL : SEQ_COL;
      SEQ_EOL:  seq_after = SEQ_IDLE;
      default:  seq_after = SEQ_IDLE;
    endcase

    state_d = state_q;
    if (accept) begin
      if (block_start_q)                           state_d = SEQ_NL;
      else if (func_i == FuncData)                 state_d = SEQ_HEXH;
      else if (line_fill_q != '0)                  state_d = SEQ_SPC;
      else                                         state_d = SEQ_IDLE;
    end else if (emit) begin
      state_d = seq_after;
    end
  end

  // character request
  always_comb begin
    tok.is_mem = 1'b0;
    tok.lit    = ChSpace;
    tok.last   = (seq_after == SEQ_IDLE);
    unique case (state_q)
      SEQ_IDLE: tok.lit = ChSpace;
      SEQ_NL:   tok.lit = ChNewline;
      SEQ_HEXH: tok.lit = hex_char(byte_q[7:4]);
      SEQ_HEXL: tok.lit = hex_char(byte_q[3:0]);
      SEQ_SPC:  tok.lit = ChSpace;
      SEQ_COL:  tok.is_mem = 1'b1;
      SEQ_EOL:  tok.lit = ChNewline;
      default:  tok.lit = ChSpace;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= SEQ_IDLE;
      block_start_q <= 1'b1;
      line_fill_q   <= '0;
    end else begin
      state_q       <= state_d;
      block_start_q <= block_start_d;
      line_fill_q   <= line_fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q    <= byte_d;
    func_q    <= func_d;
    spc_q     <= spc_d;
    col_cnt_q <= col_cnt_d;
    col_idx_q <= col_idx_d;
  end

  // ASCII column memory
  always_ff @(posedge clk_i) begin
    if (accept && func_i == FuncData) begin
      ascii_mem[line_fill_q] <= shown_char(data_byte_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit && state_q == SEQ_COL) begin
      rd_q <= ascii_mem[col_idx_q];
    end
  end

  hdlf_pack u_pack (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .tok_valid_i   (tok_valid),
    .tok_ready_o   (tok_ready),
    .tok_i         (tok),
    .mem_data_i    (rd_q),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .char_first_o  (char_first_o),
    .char_second_o (char_second_o),
    .char_count_o  (char_count_o),
    .last_of_run_o (last_of_run_o)
  );

  `HDLF_ASSERT_NEXT(a_empty_end_idle,
    accept && func_i == FuncEnd && !block_start_q && line_fill_q == '0,
    in_ready_o, "end marker with nothing pending did not finish at once")
  `HDLF_ASSERT(a_single_is_last,
    !(out_valid_o && char_count_o == CntOne) || last_of_run_o,
    "single-character result before end of run")
  `HDLF_ASSERT(a_col_in_range,
    !(state_q == SEQ_COL) || ({1'b0, col_idx_q} < col_cnt_q),
    "column read beyond filled entries")

endmodule

`default_nettype wire
